[hw/rtl/fixed_partition_fit_allocator_core_macros.svh]
// Assertion macros shared by the allocator checker.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define FPFA_ASSERT_IMP(label, clk_sig, rst_n_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define FPFA_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/fpfa_pkg.sv]
// Package with field widths, codes and defaults of the fit allocator.
`default_nettype none

package fpfa_pkg;

	localparam int MAX_BLOCKS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	localparam int KIND_W        = 1;
	localparam int SLOT_W        = 4;
	localparam int AMOUNT_W      = 16;
	localparam int STATUS_W      = 2;
	localparam int GRANT_W       = 4;
	localparam int FIT_MODE_W    = 2;
	localparam int BLOCK_COUNT_W = 5;
	localparam int CFG_INDEX_W   = 1;
	localparam int CFG_DATA_W    = 5;

	localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;

	localparam logic [STATUS_W-1:0] STATUS_LOADED        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ALLOCATED     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOCATED = 2'd2;

	localparam logic [FIT_MODE_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [FIT_MODE_W-1:0] FIT_BEST  = 2'd1;
	localparam logic [FIT_MODE_W-1:0] FIT_WORST = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] CFG_FIT_MODE    = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

	localparam logic [BLOCK_COUNT_W-1:0] BLOCK_COUNT_RESET = 5'd16;

endpackage

`default_nettype wire

[hw/rtl/fpfa_if.sv]
// Handshake interfaces for the allocator's request and result channels.
`default_nettype none

interface fpfa_req_if
	import fpfa_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [SLOT_W-1:0]   block_slot;
	logic [AMOUNT_W-1:0] amount;

	modport source(output valid, kind, block_slot, amount, input ready);
	modport sink(input valid, kind, block_slot, amount, output ready);
endinterface

interface fpfa_rsp_if
	import fpfa_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [GRANT_W-1:0]  granted_block;

	modport source(output valid, status, granted_block, input ready);
	modport sink(input valid, status, granted_block, output ready);
endinterface

`default_nettype wire

[hw/rtl/fixed_partition_fit_allocator_core.sv]
// Fixed-partition allocator: block size table with first, best and worst fit scan.
// A load request is answered in the output register in the cycle after it is taken.
// An allocation request scans up to limit table entries, limit being the saturated block
// count, as one comparator checks one registered table read per cycle.
// A new request is taken only in idle while the output register is empty or being read.
// Reset clears all used marks, sets first fit and a block count of 16; sizes stay undefined.
`default_nettype none

module fixed_partition_fit_allocator_core
	import fpfa_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	fpfa_req_if.sink                    req,
	fpfa_rsp_if.source                  rsp,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int IDX_W    = $clog2(MAX_BLOCKS);
	localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
	localparam int CMP_W    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
	localparam int LIM_W    = (CNT_W > BLOCK_COUNT_W) ? CNT_W : BLOCK_COUNT_W;
	localparam int SZ_CMP_W = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]               state_q;
	logic [FIT_MODE_W-1:0]    fit_mode_q;
	logic [BLOCK_COUNT_W-1:0] block_count_q;

	logic [SIZE_BITS-1:0]     size_mem_q [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0]    used_q;

	logic [AMOUNT_W-1:0]      amount_q;
	logic [CNT_W-1:0]         limit_q;
	logic [CNT_W-1:0]         rd_cnt_q;
	logic                     v_s1;
	logic [SIZE_BITS-1:0]     size_s1;
	logic                     used_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic                     found_q;
	logic [IDX_W-1:0]         pick_q;
	logic [SIZE_BITS-1:0]     pick_size_q;

	logic                     out_v_q;
	logic [STATUS_W-1:0]      out_status_q;
	logic [GRANT_W-1:0]       out_grant_q;

	logic                     out_free;
	logic                     accept;
	logic                     load_acc;
	logic                     req_acc;
	logic [CMP_W-1:0]         slot_ext;
	logic                     slot_ok;
	logic [IDX_W-1:0]         wr_addr;
	logic [LIM_W-1:0]         bc_ext;
	logic [CNT_W-1:0]         limit_new;
	logic                     issue;
	logic [IDX_W-1:0]         rd_addr;
	logic                     fits;
	logic                     better;
	logic                     take;
	logic                     finish;

	assign out_free  = !out_v_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign accept    = req.valid && req.ready;
	assign load_acc  = accept && (req.kind == KIND_LOAD);
	assign req_acc   = accept && (req.kind != KIND_LOAD);

	assign slot_ext = CMP_W'(req.block_slot);
	assign slot_ok  = slot_ext < CMP_W'(MAX_BLOCKS);
	assign wr_addr  = slot_ext[IDX_W-1:0];

	assign bc_ext    = LIM_W'(block_count_q);
	assign limit_new = (bc_ext > LIM_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(bc_ext);

	assign issue   = (state_q == ST_SCAN) && (rd_cnt_q < limit_q);
	assign rd_addr = rd_cnt_q[IDX_W-1:0];
	assign finish  = (state_q == ST_FIN) && out_free;

	assign fits = !used_s1 && (SZ_CMP_W'(size_s1) >= SZ_CMP_W'(amount_q));

	always_comb begin
		case (fit_mode_q)
			FIT_BEST:  better = size_s1 < pick_size_q;
			FIT_WORST: better = size_s1 > pick_size_q;
			FIT_FIRST: better = 1'b0;
			default:   better = 1'b0;
		endcase
		take = v_s1 && fits && (!found_q || better);
	end

	always_ff @(posedge clk) begin
		if (load_acc && slot_ok) begin
			size_mem_q[wr_addr] <= SIZE_BITS'(req.amount);
		end
		if (issue) begin
			size_s1 <= size_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			used_s1 <= used_q[rd_addr];
			idx_s1  <= rd_addr;
		end
		if (req_acc) begin
			amount_q <= req.amount;
		end
		if (take) begin
			pick_q      <= idx_s1;
			pick_size_q <= size_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= FIT_FIRST;
			block_count_q <= BLOCK_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIT_MODE:    fit_mode_q    <= cfg_wdata[FIT_MODE_W-1:0];
				CFG_BLOCK_COUNT: block_count_q <= cfg_wdata[BLOCK_COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			limit_q  <= '0;
			rd_cnt_q <= '0;
			v_s1     <= 1'b0;
			found_q  <= 1'b0;
			used_q   <= '0;
		end else begin
			if (load_acc && slot_ok) begin
				used_q[wr_addr] <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						state_q  <= ST_SCAN;
						limit_q  <= limit_new;
						rd_cnt_q <= '0;
						v_s1     <= 1'b0;
						found_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					v_s1 <= issue;
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (take) begin
						found_q <= 1'b1;
					end
					if (!issue && !v_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (found_q) begin
							used_q[pick_q] <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_acc || finish) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_acc) begin
			out_status_q <= STATUS_LOADED;
			out_grant_q  <= '0;
		end else if (finish) begin
			out_status_q <= found_q ? STATUS_ALLOCATED : STATUS_NOT_ALLOCATED;
			out_grant_q  <= found_q ? GRANT_W'(pick_q) : '0;
		end
	end

	assign rsp.valid         = out_v_q;
	assign rsp.status        = out_status_q;
	assign rsp.granted_block = out_grant_q;

endmodule

`default_nettype wire

[hw/rtl/fpfa_checker.sv]
// Port-level assertion checker for the allocator, bound to the top level.
`default_nettype none
`include "fixed_partition_fit_allocator_core_macros.svh"

module fpfa_checker
	import fpfa_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_valid,
	input wire logic                req_ready,
	input wire logic [KIND_W-1:0]   req_kind,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire logic [STATUS_W-1:0] rsp_status,
	input wire logic [GRANT_W-1:0]  rsp_granted_block
);

	`FPFA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_granted_block), "stalled result changed")
	`FPFA_ASSERT_NEXT(a_load_answer, clk, arst_n, req_valid && req_ready && (req_kind == KIND_LOAD), rsp_valid && (rsp_status == STATUS_LOADED), "load not answered next cycle")
	`FPFA_ASSERT_IMP(a_no_take_when_full, clk, arst_n, req_valid && req_ready, !rsp_valid || rsp_ready, "request taken while result is stalled")
	`FPFA_ASSERT_IMP(a_grant_zero, clk, arst_n, rsp_valid && (rsp_status != STATUS_ALLOCATED), rsp_granted_block == '0, "nonzero block index without a grant")
	`FPFA_ASSERT_IMP(a_status_legal, clk, arst_n, rsp_valid, (rsp_status == STATUS_LOADED) || (rsp_status == STATUS_ALLOCATED) || (rsp_status == STATUS_NOT_ALLOCATED), "illegal status code")

endmodule

bind fixed_partition_fit_allocator_core fpfa_checker u_fpfa_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.req_kind          (req.kind),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_granted_block (rsp.granted_block)
);

`default_nettype wire
